// ===== rtl/dlpd_pkg.sv =====
// Shared constants and types for the decimal length-prefix deframer.
package dlpd_pkg;

	localparam int BYTE_W           = 8;
	localparam int LEN_W            = 27;
	localparam int HPOS_W           = 4;
	localparam int MAX_HEADER_WIDTH = 8;

	localparam logic [LEN_W-1:0]  LEN_MAX   = {LEN_W{1'b1}};
	localparam logic [HPOS_W-1:0] HW_RESET  = HPOS_W'(MAX_HEADER_WIDTH);
	localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

	// Header state after one header character
	typedef struct packed {
		logic [LEN_W-1:0]  length;
		logic              closed;
		logic [HPOS_W-1:0] pos;
		logic              done;
	} hdr_next_t;

endpackage

// ===== rtl/dlpd_hdr.sv =====
// Header character step: decimal digit accumulation and header width check.
module dlpd_hdr (
	input  logic [dlpd_pkg::HPOS_W-1:0] header_width,
	input  logic [dlpd_pkg::BYTE_W-1:0] data_byte,
	input  logic [dlpd_pkg::LEN_W-1:0]  frame_length,
	input  logic                        number_closed,
	input  logic [dlpd_pkg::HPOS_W-1:0] header_pos,
	output dlpd_pkg::hdr_next_t         nxt
);
	import dlpd_pkg::*;

	logic              is_digit;
	logic [LEN_W+3:0]  acc;
	logic [HPOS_W-1:0] eff_w;
	logic [HPOS_W-1:0] pos_inc;

	assign is_digit = !number_closed && (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);

	// Multiply by ten with shifts, add the digit
	assign acc = ({4'b0, frame_length} << 3) + ({4'b0, frame_length} << 1)
		+ (LEN_W+4)'(data_byte - CHAR_ZERO);

	// Clamp the configured width to the supported range
	always_comb begin
		if (header_width == '0) begin
			eff_w = HPOS_W'(1);
		end else if (header_width > HPOS_W'(MAX_HEADER_WIDTH)) begin
			eff_w = HPOS_W'(MAX_HEADER_WIDTH);
		end else begin
			eff_w = header_width;
		end
	end

	assign pos_inc = header_pos + HPOS_W'(1);

	// Saturate the length, close the number on the first non-digit
	always_comb begin
		nxt.length = frame_length;
		nxt.closed = number_closed;
		if (is_digit) begin
			if (acc > (LEN_W+4)'(LEN_MAX)) begin
				nxt.length = LEN_MAX;
			end else begin
				nxt.length = acc[LEN_W-1:0];
			end
		end else begin
			nxt.closed = 1'b1;
		end
		nxt.pos  = pos_inc;
		nxt.done = (pos_inc >= eff_w);
	end

endmodule

// ===== rtl/decimal_length_prefix_deframer.sv =====
// Top level: input stage, frame state, and result register of the deframer.
// Data path: a request is registered in the input stage on acceptance, and its
// result, if it has one, is then loaded into the output register.
// Throughput: one byte per cycle, set by the single input stage feeding the
// result register; a stalled output holds the input stage only when a result is due.
// Reset: arst_n clears all frame state, empties both stages, sets header_width to 8.
module decimal_length_prefix_deframer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [dlpd_pkg::HPOS_W-1:0] cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [dlpd_pkg::BYTE_W-1:0] data_byte,
	input  logic                        stream_end,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [dlpd_pkg::BYTE_W-1:0] out_byte,
	output logic                        frame_last,
	output logic                        frame_empty,
	output logic                        frame_cut
);
	import dlpd_pkg::*;

	logic [HPOS_W-1:0] header_width_q;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              end_s1;

	logic              in_payload_q;
	logic [HPOS_W-1:0] header_pos_q;
	logic              number_closed_q;
	logic [LEN_W-1:0]  frame_length_q;
	logic [LEN_W-1:0]  bytes_left_q;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;
	logic              out_empty_q;
	logic              out_cut_q;

	hdr_next_t         hnxt;
	logic [LEN_W-1:0]  left_dec;
	logic              has_res;
	logic [BYTE_W-1:0] res_byte;
	logic              res_last;
	logic              res_empty;
	logic              res_cut;
	logic              clear;
	logic              advance;
	logic              out_free;

	dlpd_hdr u_hdr (
		.header_width  (header_width_q),
		.data_byte     (byte_s1),
		.frame_length  (frame_length_q),
		.number_closed (number_closed_q),
		.header_pos    (header_pos_q),
		.nxt           (hnxt)
	);

	assign left_dec = bytes_left_q - LEN_W'(bytes_left_q != '0);

	// Decide the result and whether the frame closes
	always_comb begin
		has_res   = 1'b0;
		res_byte  = '0;
		res_last  = 1'b1;
		res_empty = 1'b1;
		res_cut   = 1'b0;
		clear     = 1'b0;
		if (in_payload_q) begin
			has_res   = 1'b1;
			res_byte  = byte_s1;
			res_empty = 1'b0;
			if (left_dec == '0) begin
				clear = 1'b1;
			end else if (end_s1) begin
				res_cut = 1'b1;
				clear   = 1'b1;
			end else begin
				res_last = 1'b0;
			end
		end else if (hnxt.done) begin
			if (hnxt.length == '0) begin
				has_res = 1'b1;
				clear   = 1'b1;
			end else if (end_s1) begin
				has_res = 1'b1;
				res_cut = 1'b1;
				clear   = 1'b1;
			end
		end else if (end_s1) begin
			has_res = 1'b1;
			res_cut = 1'b1;
			clear   = 1'b1;
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && (!has_res || out_free);
	assign in_ready = !valid_s1 || advance;

	// Hold the configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_width_q <= HW_RESET;
		end else if (cfg_wr_en) begin
			header_width_q <= cfg_wr_data;
		end
	end

	// Capture accepted requests into the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			end_s1  <= stream_end;
		end
	end

	// Advance the frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q    <= 1'b0;
			header_pos_q    <= '0;
			number_closed_q <= 1'b0;
			frame_length_q  <= '0;
			bytes_left_q    <= '0;
		end else if (advance) begin
			if (clear) begin
				in_payload_q    <= 1'b0;
				header_pos_q    <= '0;
				number_closed_q <= 1'b0;
				frame_length_q  <= '0;
				bytes_left_q    <= '0;
			end else if (in_payload_q) begin
				bytes_left_q <= left_dec;
			end else if (hnxt.done) begin
				in_payload_q    <= 1'b1;
				bytes_left_q    <= hnxt.length;
				frame_length_q  <= hnxt.length;
				header_pos_q    <= '0;
				number_closed_q <= 1'b0;
			end else begin
				header_pos_q    <= hnxt.pos;
				number_closed_q <= hnxt.closed;
				frame_length_q  <= hnxt.length;
			end
		end
	end

	// Load the result register, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && has_res) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_res) begin
			out_byte_q  <= res_byte;
			out_last_q  <= res_last;
			out_empty_q <= res_empty;
			out_cut_q   <= res_cut;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign frame_last  = out_last_q;
	assign frame_empty = out_empty_q;
	assign frame_cut   = out_cut_q;

endmodule
